// ===== rtl/ble_pkg.sv =====
// shared constants, types and register indexes for the battery level estimator
// no dependencies; compiled before the interfaces and the top level
`default_nettype none

package ble_pkg;

    localparam int WINDOW_LEN = 50;

    localparam int VOLT_W    = 12;
    localparam int LEVEL_W   = 7;
    localparam int SLOT_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int TOTAL_W   = $clog2(((1 << VOLT_W) - 1) * WINDOW_LEN + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [VOLT_W-1:0]  FLOOR_RESET   = VOLT_W'(310);
    localparam logic [VOLT_W-1:0]  CEILING_RESET = VOLT_W'(410);
    localparam logic [LEVEL_W-1:0] FULL_LEVEL    = LEVEL_W'(100);
    localparam logic [LEVEL_W-1:0] HYST_STEP     = LEVEL_W'(5);

    // percent scaling product: volts span times one hundred
    localparam int PROD_W = VOLT_W + LEVEL_W;

    // window mean by reciprocal multiply: exact for every total below 2**TOTAL_W
    localparam int MEAN_SHIFT  = TOTAL_W + SLOT_W;
    localparam int RECIP_W     = TOTAL_W + 2;
    localparam int MEAN_PROD_W = TOTAL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'(((1 << MEAN_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

    // quotient width handled by the percent divider
    localparam int PCT_STEPS  = LEVEL_W;
    localparam int STEP_W     = $clog2(PCT_STEPS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = CFG_IDX_W'(1);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_UPDATE   = 7'b0000010,
        ST_DIV_MEAN = 7'b0000100,
        ST_SCALE    = 7'b0001000,
        ST_MULT     = 7'b0010000,
        ST_DIV_PCT  = 7'b0100000,
        ST_DONE     = 7'b1000000
    } ble_state_t;

endpackage

`default_nettype wire

// ===== rtl/ble_if.sv =====
// valid/ready channel interfaces for samples in and results out
// depends on ble_pkg for field widths
`default_nettype none

interface ble_sample_if;
    import ble_pkg::*;

    logic              valid;
    logic              ready;
    logic [VOLT_W-1:0] sample_volts;

    modport source (output valid, output sample_volts, input ready);
    modport sink   (input valid, input sample_volts, output ready);
endinterface

interface ble_result_if;
    import ble_pkg::*;

    logic               valid;
    logic               ready;
    logic [VOLT_W-1:0]  mean_volts;
    logic [LEVEL_W-1:0] level_percent;

    modport source (output valid, output mean_volts, output level_percent, input ready);
    modport sink   (input valid, input mean_volts, input level_percent, output ready);
endinterface

`default_nettype wire

// ===== rtl/battery_level_estimator.sv =====
// battery level estimator top level: moving average, clamp, percent map, hysteresis
// depends on ble_pkg and the channel interfaces in ble_if.sv
`default_nettype none

// Takes one voltage sample per transfer and returns one result per sample: the
// truncated mean of a 50-entry window and a hysteresis-filtered charge percent.
// The first sample after reset stands for the whole window. An item goes from its
// transfer through window update, reciprocal multiply for the mean, clamp, scale,
// a restoring divider that resolves one percent bit per cycle, and the load of the
// result register; the block accepts no sample in the meantime. When the ceiling
// is not above the floor the divide is skipped.
// A finished result waits in the output register while the next sample is taken;
// a second finished result holds the block until the first one is taken.
// Floor and ceiling may only be written while no sample is in flight.

module battery_level_estimator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    ble_sample_if.sink                         sample_in,
    ble_result_if.source                       result_out,
    input  wire logic                          cfg_we,
    input  wire logic [ble_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ble_pkg::VOLT_W-1:0]    cfg_data
);
    import ble_pkg::*;

    ble_state_t          state_reg, state_next;

    logic [VOLT_W-1:0]   floor_reg, ceiling_reg;

    logic [VOLT_W-1:0]   window_mem [WINDOW_LEN];
    logic [VOLT_W-1:0]   rd_data_reg;
    logic                mem_we;

    logic [VOLT_W-1:0]   sample_reg, sample_next;
    logic [VOLT_W-1:0]   prime_reg, prime_next;
    logic                primed_reg, primed_next;
    logic                wrapped_reg, wrapped_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;

    // percent divider
    logic [VOLT_W-1:0]   rem_reg, rem_next;
    logic [VOLT_W-1:0]   bits_reg, bits_next;
    logic [VOLT_W-1:0]   divisor_reg, divisor_next;
    logic [STEP_W-1:0]   count_reg, count_next;
    logic [VOLT_W:0]     trial;
    logic                qbit;
    logic [VOLT_W-1:0]   rem_step;
    logic [VOLT_W-1:0]   bits_step;

    logic [MEAN_PROD_W-1:0] mean_prod;
    logic [VOLT_W-1:0]   mean_calc;

    logic [VOLT_W-1:0]   mean_reg, mean_next;
    logic [VOLT_W-1:0]   span_reg, span_next;
    logic [LEVEL_W-1:0]  shown_reg, shown_next;

    logic                out_valid_reg, out_valid_next;
    logic [VOLT_W-1:0]   out_mean_reg, out_mean_next;
    logic [LEVEL_W-1:0]  out_level_reg, out_level_next;

    logic                in_xfer;
    logic [VOLT_W-1:0]   old_val;
    logic [TOTAL_W-1:0]  total_calc;
    logic [VOLT_W-1:0]   clamped;
    logic [PROD_W-1:0]   product;
    logic                degenerate;
    logic [LEVEL_W-1:0]  pct;
    logic [LEVEL_W-1:0]  pct_diff;
    logic [LEVEL_W-1:0]  level_new;

    assign sample_in.ready          = (state_reg == ST_IDLE);
    assign in_xfer                  = sample_in.valid && sample_in.ready;
    assign result_out.valid         = out_valid_reg;
    assign result_out.mean_volts    = out_mean_reg;
    assign result_out.level_percent = out_level_reg;

    assign degenerate = (ceiling_reg <= floor_reg);

    // one restoring step
    assign trial     = {rem_reg, bits_reg[VOLT_W-1]};
    assign qbit      = (trial >= {1'b0, divisor_reg});
    assign rem_step  = qbit ? VOLT_W'(trial - {1'b0, divisor_reg}) : trial[VOLT_W-1:0];
    assign bits_step = {bits_reg[VOLT_W-2:0], qbit};

    // total divided by the window length
    assign mean_prod = MEAN_PROD_W'(total_reg) * MEAN_PROD_W'(MEAN_RECIP);
    assign mean_calc = mean_prod[MEAN_SHIFT +: VOLT_W];

    // entries not yet overwritten since priming still hold the priming sample
    assign old_val = wrapped_reg ? rd_data_reg : prime_reg;

    always_comb
    begin
        if (!primed_reg)
        begin
            total_calc = TOTAL_W'(sample_reg) * TOTAL_W'(WINDOW_LEN);
        end
        else
        begin
            total_calc = total_reg - TOTAL_W'(old_val) + TOTAL_W'(sample_reg);
        end
    end

    always_comb
    begin
        if (bits_reg < floor_reg)
        begin
            clamped = floor_reg;
        end
        else if (bits_reg > ceiling_reg)
        begin
            clamped = ceiling_reg;
        end
        else
        begin
            clamped = bits_reg;
        end
    end

    assign product = PROD_W'(span_reg) * PROD_W'(FULL_LEVEL);

    assign pct       = bits_reg[LEVEL_W-1:0];
    assign pct_diff  = (pct > shown_reg) ? (pct - shown_reg) : (shown_reg - pct);
    assign level_new = ((pct_diff > HYST_STEP) || (pct == FULL_LEVEL)) ? pct : shown_reg;

    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        prime_next     = prime_reg;
        primed_next    = primed_reg;
        wrapped_next   = wrapped_reg;
        slot_next      = slot_reg;
        total_next     = total_reg;
        rem_next       = rem_reg;
        bits_next      = bits_reg;
        divisor_next   = divisor_reg;
        count_next     = count_reg;
        mean_next      = mean_reg;
        span_next      = span_reg;
        shown_next     = shown_reg;
        out_mean_next  = out_mean_reg;
        out_level_next = out_level_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;

        if (out_valid_reg && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    sample_next = sample_in.sample_volts;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                total_next = total_calc;
                if (!primed_reg)
                begin
                    prime_next   = sample_reg;
                    primed_next  = 1'b1;
                    wrapped_next = 1'b0;
                    slot_next    = '0;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (slot_reg == SLOT_W'(WINDOW_LEN - 1))
                    begin
                        slot_next    = '0;
                        wrapped_next = 1'b1;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
                state_next = ST_DIV_MEAN;
            end
            ST_DIV_MEAN:
            begin
                bits_next  = mean_calc;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mean_next  = bits_reg;
                span_next  = clamped - floor_reg;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                if (degenerate)
                begin
                    bits_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next     = product[PROD_W-1:PCT_STEPS];
                    bits_next    = {product[PCT_STEPS-1:0], (VOLT_W - PCT_STEPS)'(0)};
                    divisor_next = ceiling_reg - floor_reg;
                    count_next   = STEP_W'(PCT_STEPS);
                    state_next   = ST_DIV_PCT;
                end
            end
            ST_DIV_PCT:
            begin
                rem_next   = rem_step;
                bits_next  = bits_step;
                count_next = count_reg - 1'b1;
                if (count_reg == STEP_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    shown_next     = level_new;
                    out_mean_next  = mean_reg;
                    out_level_next = level_new;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            floor_reg     <= FLOOR_RESET;
            ceiling_reg   <= CEILING_RESET;
            primed_reg    <= 1'b0;
            wrapped_reg   <= 1'b0;
            slot_reg      <= '0;
            total_reg     <= '0;
            shown_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            primed_reg    <= primed_next;
            wrapped_reg   <= wrapped_next;
            slot_reg      <= slot_next;
            total_reg     <= total_next;
            shown_reg     <= shown_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == CFG_FLOOR))
            begin
                floor_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_CEILING))
            begin
                ceiling_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        prime_reg     <= prime_next;
        rem_reg       <= rem_next;
        bits_reg      <= bits_next;
        divisor_reg   <= divisor_next;
        mean_reg      <= mean_next;
        span_reg      <= span_next;
        out_mean_reg  <= out_mean_next;
        out_level_reg <= out_level_next;
    end

    // window memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[slot_reg] <= sample_reg;
        end
        rd_data_reg <= window_mem[slot_reg];
    end

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(WINDOW_LEN - 1))
        else $error("write slot beyond window");

    a_slot_zero_unprimed: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> (slot_reg == '0) && !wrapped_reg)
        else $error("window advanced before priming");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_PCT) |-> (divisor_reg != '0))
        else $error("percent divide by zero");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_level_reg <= FULL_LEVEL))
        else $error("reported level above full");

    a_xfer_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_UPDATE))
        else $error("accepted sample not processed");

endmodule

`default_nettype wire
